### hw/rtl/pip_pkg.sv
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VIDX_W       = 5;
   localparam int COORD_W      = 16;
   localparam int COUNT_W      = 6;
   localparam int ENTRY_W      = 2 * COORD_W;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register index, taken from the word address bit of paddr.
   localparam logic REG_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic valid;
      logic first;
   } rd_ctl_type;

   typedef struct packed {
      logic flip;
      logic busy;
   } edge_stat_type;

endpackage

`default_nettype wire

### hw/rtl/pip_vertex_ram.sv
`default_nettype none

module pip_vertex_ram (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [pip_pkg::VIDX_W-1:0]    wr_addr,
   input  wire logic [pip_pkg::ENTRY_W-1:0]   wr_data,
   input  wire logic                          rd_en,
   input  wire logic [pip_pkg::VIDX_W-1:0]    rd_addr,
   output logic      [pip_pkg::ENTRY_W-1:0]   rd_data
);

   logic [pip_pkg::ENTRY_W-1:0] mem_ff [pip_pkg::MAX_VERTICES];
   logic [pip_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pip_edge_unit.sv
`default_nettype none

module pip_edge_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pip_pkg::rd_ctl_type                 rd_ctl,
   input  wire logic        [pip_pkg::ENTRY_W-1:0]  rd_data,
   input  wire logic signed [pip_pkg::COORD_W-1:0]  px,
   input  wire logic signed [pip_pkg::COORD_W-1:0]  py,
   output pip_pkg::edge_stat_type                   stat
);

   logic        [pip_pkg::ENTRY_W-1:0] prev_ff;
   logic signed [pip_pkg::COORD_W-1:0] x0, y0, x1, y1;
   logic                               above0, above1;

   logic                               e_valid_ff, e_cross_ff, e_above_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  dy1p_ff, dx01_ff, dx1p_ff, dy01_ff;
   logic signed [pip_pkg::DIFF_W-1:0]  dy1p_in, dx01_in, dx1p_in, dy01_in;

   logic                               m_valid_ff, m_above_ff;
   logic signed [pip_pkg::PROD_W-1:0]  lhs_ff, rhs_ff, lhs_in, rhs_in;

   always_comb begin
      x0 = prev_ff[pip_pkg::COORD_W-1:0];
      y0 = prev_ff[pip_pkg::ENTRY_W-1:pip_pkg::COORD_W];
      x1 = rd_data[pip_pkg::COORD_W-1:0];
      y1 = rd_data[pip_pkg::ENTRY_W-1:pip_pkg::COORD_W];
      // A vertex on the point's horizontal line counts as above it.
      above0 = (y0 >= py);
      above1 = (y1 >= py);
      dy1p_in = {y1[pip_pkg::COORD_W-1], y1} - {py[pip_pkg::COORD_W-1], py};
      dx01_in = {x0[pip_pkg::COORD_W-1], x0} - {x1[pip_pkg::COORD_W-1], x1};
      dx1p_in = {x1[pip_pkg::COORD_W-1], x1} - {px[pip_pkg::COORD_W-1], px};
      dy01_in = {y0[pip_pkg::COORD_W-1], y0} - {y1[pip_pkg::COORD_W-1], y1};
      lhs_in  = dy1p_ff * dx01_ff;
      rhs_in  = dx1p_ff * dy01_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         // The first read only primes the previous vertex; it forms no edge.
         e_valid_ff <= rd_ctl.valid && !rd_ctl.first;
         m_valid_ff <= e_valid_ff && e_cross_ff;
      end
      if (rd_ctl.valid) begin
         prev_ff <= rd_data;
      end
      e_cross_ff <= (above0 != above1);
      e_above_ff <= above1;
      dy1p_ff    <= dy1p_in;
      dx01_ff    <= dx01_in;
      dx1p_ff    <= dx1p_in;
      dy01_ff    <= dy01_in;
      m_above_ff <= e_above_ff;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
   end

   assign stat.flip = m_valid_ff && ((lhs_ff >= rhs_ff) == m_above_ff);
   assign stat.busy = e_valid_ff || m_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/point_in_polygon_test.sv
`default_nettype none

// Point-in-polygon crossing-number test. A vertex write (req_type 0) stores
// one (x, y) vertex and returns no result. A query (req_type 1) walks the
// polygon formed by the first vertex_count stored vertices, beginning with
// the closing edge from the last vertex to the first, and returns one inside
// flag. A query stalls the input from its transfer until its flag enters the
// output register: one vertex store read per edge plus one priming read,
// then the subtract, multiply and compare stages draining. An empty polygon
// answers outside without reading the store. vertex_count above the store
// depth is treated as the full store. The finished flag sits in an output
// register, so the next item is taken while it waits for transfer; a query
// that finishes while that register is still stalled waits until it frees.
// Querying a vertex that was never written yields an undefined answer.
module point_in_polygon_test (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic [pip_pkg::VIDX_W-1:0]        req_vertex_index,
   input  wire logic [pip_pkg::COORD_W-1:0]       req_coord_x,
   input  wire logic [pip_pkg::COORD_W-1:0]       req_coord_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_inside_res,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pip_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [pip_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [pip_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                           state_ff;
   logic [pip_pkg::COUNT_W-1:0]         count_ff;
   logic [pip_pkg::COUNT_W-1:0]         n_ff, n_in, n_dec, step_ff, step_dec;
   logic [pip_pkg::VIDX_W-1:0]          last_idx_ff, rd_addr;
   logic signed [pip_pkg::COORD_W-1:0]  px_ff, py_ff;
   logic                                inside_ff;
   logic                                rsp_valid_ff, rsp_inside_ff;
   logic                                rd_valid_ff, rd_first_ff;
   logic                                rd_en, wr_en, query_acc, csr_wr;
   logic [pip_pkg::ENTRY_W-1:0]         rd_data;
   pip_pkg::rd_ctl_type                 rd_ctl;
   pip_pkg::edge_stat_type              edge_stat;

   always_comb begin
      n_in      = (count_ff > pip_pkg::COUNT_W'(pip_pkg::MAX_VERTICES))
                  ? pip_pkg::COUNT_W'(pip_pkg::MAX_VERTICES) : count_ff;
      n_dec     = n_in - 1'b1;
      step_dec  = step_ff - 1'b1;
      rd_en     = (state_ff == ST_READ);
      // Step zero reads the last vertex, then the vertices in order.
      rd_addr   = (step_ff == '0) ? last_idx_ff : step_dec[pip_pkg::VIDX_W-1:0];
      wr_en     = req_valid && !req_stall && (req_type == pip_pkg::REQ_WRITE);
      query_acc = req_valid && !req_stall && (req_type == pip_pkg::REQ_QUERY);
      csr_wr    = psel && penable && pwrite && pready
                  && (paddr[2] == pip_pkg::REG_VERTEX_COUNT);
      rd_ctl.valid = rd_valid_ff;
      rd_ctl.first = rd_first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         // In the finish state the result register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr) begin
            count_ff <= pwdata[pip_pkg::COUNT_W-1:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (query_acc) begin
                  step_ff   <= '0;
                  inside_ff <= 1'b0;
                  state_ff  <= (n_in == '0) ? ST_FINISH : ST_READ;
               end
            end
            ST_READ: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == n_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!rd_valid_ff && !edge_stat.busy) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= inside_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (edge_stat.flip) begin
            inside_ff <= !inside_ff;
         end
      end
      rd_first_ff <= rd_en && (step_ff == '0);
      if (query_acc) begin
         px_ff       <= req_coord_x;
         py_ff       <= req_coord_y;
         n_ff        <= n_in;
         last_idx_ff <= n_dec[pip_pkg::VIDX_W-1:0];
      end
   end

   pip_vertex_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_coord_y, req_coord_x}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_edge_unit u_edge (
      .clock   (clock),
      .reset   (reset),
      .rd_ctl  (rd_ctl),
      .rd_data (rd_data),
      .px      (px_ff),
      .py      (py_ff),
      .stat    (edge_stat)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign pready         = 1'b1;
   assign prdata         = (paddr[2] == pip_pkg::REG_VERTEX_COUNT)
                           ? {{(pip_pkg::CSR_DATA_W - pip_pkg::COUNT_W){1'b0}}, count_ff}
                           : '0;

endmodule

`default_nettype wire

### hw/rtl/pip_checker.sv
`default_nettype none

module pip_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_type,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_inside_res,
   input wire logic                              psel,
   input wire logic                              penable,
   input wire logic                              pwrite,
   input wire logic [pip_pkg::CSR_ADDR_W-1:0]    paddr,
   input wire logic [pip_pkg::CSR_DATA_W-1:0]    pwdata,
   input wire logic [pip_pkg::CSR_DATA_W-1:0]    prdata
);

   // A query keeps the block busy for at least the cycle after its transfer.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == pip_pkg::REQ_QUERY) |=> req_stall)
      else $error("query transfer not followed by a busy cycle");

   // A new result only appears directly after the block was busy.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without preceding work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res))
      else $error("stalled result changed or dropped");

   // The vertex count register reads back what was written.
   a_count_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && (paddr[2] == pip_pkg::REG_VERTEX_COUNT)
      |=> prdata[pip_pkg::COUNT_W-1:0] == $past(pwdata[pip_pkg::COUNT_W-1:0]))
      else $error("vertex count readback mismatch");

endmodule

bind point_in_polygon_test pip_checker u_checker (.*);

`default_nettype wire

### bench/point_in_polygon_test_tb.sv
`default_nettype none

module point_in_polygon_test_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int ITEM_TARGET   = 880;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int FULL_SPAN     = 32767;
   localparam logic [pip_pkg::COORD_W-1:0] COORD_MIN = 16'h8000;
   localparam logic [pip_pkg::COORD_W-1:0] COORD_MAX = 16'h7FFF;

   class inside_scoreboard;
      logic signed [pip_pkg::COORD_W-1:0] vert_x [pip_pkg::MAX_VERTICES];
      logic signed [pip_pkg::COORD_W-1:0] vert_y [pip_pkg::MAX_VERTICES];
      logic [pip_pkg::COUNT_W-1:0] vertex_count;
      bit due_flags [$];
      int mismatches;

      function new();
         for (int i = 0; i < pip_pkg::MAX_VERTICES; i++) begin
            vert_x[i] = '0;
            vert_y[i] = '0;
         end
         vertex_count = '0;
         mismatches = 0;
      endfunction

      function void set_count(input logic [pip_pkg::COUNT_W-1:0] n);
         vertex_count = n;
      endfunction

      // Crossing-number test; the first edge walked is the closing one.
      function bit crossing_parity(input logic signed [pip_pkg::COORD_W-1:0] px,
                                   input logic signed [pip_pkg::COORD_W-1:0] py);
         int n;
         bit odd;
         bit above_prev;
         bit above_cur;
         logic signed [pip_pkg::COORD_W-1:0] x0, y0, x1, y1;
         longint lhs, rhs;
         n = (vertex_count > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES
                                                    : int'(vertex_count);
         odd = 1'b0;
         if (n == 0)
            return 1'b0;
         x0 = vert_x[n-1];
         y0 = vert_y[n-1];
         above_prev = (y0 >= py);
         for (int i = 0; i < n; i++) begin
            x1 = vert_x[i];
            y1 = vert_y[i];
            above_cur = (y1 >= py);
            if (above_prev != above_cur) begin
               lhs = (longint'(y1) - longint'(py)) * (longint'(x0) - longint'(x1));
               rhs = (longint'(x1) - longint'(px)) * (longint'(y0) - longint'(y1));
               if ((lhs >= rhs) == above_cur)
                  odd = !odd;
            end
            above_prev = above_cur;
            x0 = x1;
            y0 = y1;
         end
         return odd;
      endfunction

      function void note_item(input logic kind, input logic [pip_pkg::VIDX_W-1:0] idx,
                              input logic signed [pip_pkg::COORD_W-1:0] x,
                              input logic signed [pip_pkg::COORD_W-1:0] y);
         if (kind == pip_pkg::REQ_WRITE) begin
            if (idx < pip_pkg::MAX_VERTICES) begin
               vert_x[idx] = x;
               vert_y[idx] = y;
            end
         end else begin
            due_flags.push_back(crossing_parity(x, y));
         end
      endfunction

      function void flag_error(input string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%s", msg);
      endfunction

      function void check_inside(input logic got);
         bit want;
         if (due_flags.size() == 0) begin
            flag_error($sformatf("inside flag %0b arrived with no query outstanding", got));
         end else begin
            want = due_flags.pop_front();
            if (got !== want)
               flag_error($sformatf("inside flag mismatch: expected %0b, got %0b", want, got));
         end
      endfunction

      function int waiting();
         return due_flags.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_type;
   logic [pip_pkg::VIDX_W-1:0]     req_vertex_index;
   logic [pip_pkg::COORD_W-1:0]    req_coord_x;
   logic [pip_pkg::COORD_W-1:0]    req_coord_y;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic                           rsp_inside_res;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [pip_pkg::CSR_ADDR_W-1:0] paddr;
   logic [pip_pkg::CSR_DATA_W-1:0] pwdata;
   logic [pip_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   inside_scoreboard board = new();

   int items_sent = 0;
   bit sender_gappy = 1'b0;
   bit rsp_choppy = 1'b0;
   int long_hold_requests = 0;
   int long_holds_served = 0;
   int stall_left = 0;

   point_in_polygon_test u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [pip_pkg::COORD_W-1:0] coord_in(input int span);
      return pip_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [pip_pkg::COORD_W-1:0] vertex_coord(input int span);
      if (span == FULL_SPAN && $urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      return coord_in(span);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_item(req_type, req_vertex_index, req_coord_x, req_coord_y);
         if (rsp_valid && !rsp_stall)
            board.check_inside(rsp_inside_res);
      end
   end

   // Receiver: random stall runs, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (long_holds_served != long_hold_requests) begin
         long_holds_served++;
         stall_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_choppy && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = idle_length();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input logic kind, input logic [pip_pkg::VIDX_W-1:0] idx,
                            input logic [pip_pkg::COORD_W-1:0] x,
                            input logic [pip_pkg::COORD_W-1:0] y);
      int gap;
      gap = sender_gappy ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_vertex_index <= idx;
      req_coord_x      <= x;
      req_coord_y      <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering items and wait until every query has had its answer.
   // The first edge lets the monitor note the last transfer before counting.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pip_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [pip_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_vertex_count(input logic [pip_pkg::COUNT_W-1:0] n);
      drain_results();
      csr_write(pip_pkg::CSR_ADDR_W'(4 * pip_pkg::REG_VERTEX_COUNT),
                pip_pkg::CSR_DATA_W'(n));
      board.set_count(n);
   endtask

   task automatic send_query_near(input int span, input int used);
      logic [pip_pkg::COORD_W-1:0] x, y;
      int a, b;
      a = (used > 0) ? $urandom_range(0, used - 1) : 0;
      b = (used > 0) ? (a + 1) % used : 0;
      case ($urandom_range(0, 5))
         0: begin
            x = pip_pkg::COORD_W'($urandom);
            y = pip_pkg::COORD_W'($urandom);
         end
         1: begin
            x = coord_in(span);
            y = coord_in(span);
         end
         2: begin
            x = board.vert_x[a];
            y = board.vert_y[a];
         end
         3: begin
            x = coord_in(span);
            y = board.vert_y[a];
         end
         4: begin
            x = pip_pkg::COORD_W'((int'(board.vert_x[a]) + int'(board.vert_x[b])) >>> 1);
            y = pip_pkg::COORD_W'((int'(board.vert_y[a]) + int'(board.vert_y[b])) >>> 1);
         end
         default: begin
            x = board.vert_x[a] + pip_pkg::COORD_W'($urandom_range(0, 4))
                - pip_pkg::COORD_W'(2);
            y = board.vert_y[a] + pip_pkg::COORD_W'($urandom_range(0, 4))
                - pip_pkg::COORD_W'(2);
         end
      endcase
      send_item(pip_pkg::REQ_QUERY, pip_pkg::VIDX_W'($urandom), x, y);
   endtask

   task automatic run_directed();
      set_vertex_count(pip_pkg::COUNT_W'(0));
      // An empty polygon answers outside wherever the point is.
      send_item(pip_pkg::REQ_QUERY, '0, '0, '0);
      send_item(pip_pkg::REQ_QUERY, '1, COORD_MIN, COORD_MAX);

      // Square spanning the whole coordinate range.
      send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(0), COORD_MIN, COORD_MIN);
      send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(1), COORD_MAX, COORD_MIN);
      send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(2), COORD_MAX, COORD_MAX);
      send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(3), COORD_MIN, COORD_MAX);
      set_vertex_count(pip_pkg::COUNT_W'(4));
      send_item(pip_pkg::REQ_QUERY, '0, '0, '0);
      send_item(pip_pkg::REQ_QUERY, '1, COORD_MIN, COORD_MIN);
      send_item(pip_pkg::REQ_QUERY, '0, COORD_MAX, '0);
      send_item(pip_pkg::REQ_QUERY, '1, '0, COORD_MAX);
      send_item(pip_pkg::REQ_QUERY, '0, COORD_MIN, '0);
      send_item(pip_pkg::REQ_QUERY, '1, 16'd100, COORD_MIN);

      // Triangle from the first three corners; the origin lies on its long side.
      set_vertex_count(pip_pkg::COUNT_W'(3));
      send_item(pip_pkg::REQ_QUERY, '0, '0, '0);
      send_item(pip_pkg::REQ_QUERY, '0, 16'd1000, -16'sd1000);
      send_item(pip_pkg::REQ_QUERY, '0, -16'sd1000, 16'd1000);

      // Pull the second corner to the origin, onto the line between its neighbours.
      set_vertex_count(pip_pkg::COUNT_W'(4));
      send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(1), '0, '0);
      send_item(pip_pkg::REQ_QUERY, '0, 16'd16000, '0);
      send_item(pip_pkg::REQ_QUERY, '0, -16'sd16000, '0);
   endtask

   task automatic run_random();
      int phase;
      int span;
      int used;
      int qn;
      int r;
      logic [pip_pkg::COUNT_W-1:0] n;
      phase = 0;
      sender_gappy = 1'b1;
      rsp_choppy = 1'b1;
      // Fill the whole store first so that any vertex count is legal from here on.
      for (int i = 0; i < pip_pkg::MAX_VERTICES; i++)
         send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(i), vertex_coord(FULL_SPAN),
                   vertex_coord(FULL_SPAN));
      while (items_sent < ITEM_TARGET) begin
         phase++;
         case (phase)
            1: n = pip_pkg::COUNT_W'(pip_pkg::MAX_VERTICES);
            2: n = '1;
            4: n = '0;
            default: begin
               r = $urandom_range(0, 19);
               if (r == 0)
                  n = pip_pkg::COUNT_W'(0);
               else if (r == 1)
                  n = pip_pkg::COUNT_W'($urandom_range(1, 2));
               else if (r == 2)
                  n = pip_pkg::COUNT_W'(pip_pkg::MAX_VERTICES);
               else if (r == 3)
                  n = pip_pkg::COUNT_W'($urandom_range(pip_pkg::MAX_VERTICES + 1,
                                                       (1 << pip_pkg::COUNT_W) - 1));
               else if (r == 4)
                  n = pip_pkg::COUNT_W'($urandom_range(11, pip_pkg::MAX_VERTICES - 1));
               else
                  n = pip_pkg::COUNT_W'($urandom_range(3, 10));
            end
         endcase
         case ($urandom_range(0, 3))
            0: span = 4;
            1: span = 64;
            2: span = 2000;
            default: span = FULL_SPAN;
         endcase
         set_vertex_count(n);
         sender_gappy = (phase == 3) ? 1'b0 : ($urandom_range(0, 2) != 0);
         rsp_choppy = ($urandom_range(0, 2) != 0);
         used = (n > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : int'(n);
         for (int i = 0; i < used; i++)
            send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'(i), vertex_coord(span),
                      vertex_coord(span));
         qn = $urandom_range(6, 20);
         for (int q = 0; q < qn; q++) begin
            // The receiver holds off while queries keep coming, so the input backs up.
            if (phase == 3 && q == 0)
               long_hold_requests++;
            if (phase == 5 && q == qn / 2)
               drain_results();
            if ($urandom_range(0, 19) == 0)
               send_item(pip_pkg::REQ_WRITE, pip_pkg::VIDX_W'($urandom), vertex_coord(span),
                         vertex_coord(span));
            send_query_near(span, used);
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= pip_pkg::REQ_WRITE;
      req_vertex_index <= '0;
      req_coord_x      <= '0;
      req_coord_y      <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      drain_results();
      if (board.mismatches == 0)
         $display("point_in_polygon_test verification clean");
      else
         $display("point_in_polygon_test verification failed");
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("point_in_polygon_test verification failed");
      $finish;
   end

endmodule

`default_nettype wire
